// ----- sv/assert_macros.svh -----
// Assertion helpers used by fpap_parse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define FPAP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fpap assertion failed");

// Antecedent in this cycle implies consequent in the next.
`define FPAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpap assertion failed");

`endif

// ----- sv/fpap_pkg.sv -----
`default_nettype none

package fpap_pkg;

    localparam logic [7:0] SEP_CHAR     = 8'h2C;
    localparam logic [2:0] LAST_COMMA   = 3'd5;
    localparam logic [2:0] ADDR_NUMBERS = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_FEW  = 2'd1,
        ST_TOO_MANY = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] host_address;
        logic [15:0] port_number;
        t_status     parse_status;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/fpap_in_if.sv -----
`default_nettype none

interface fpap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

// ----- sv/fpap_out_if.sv -----
`default_nettype none

interface fpap_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] host_address;
    logic [15:0] port_number;
    logic [1:0]  parse_status;

    modport source (output valid, output host_address, output port_number,
                    output parse_status, input ready);
    modport sink   (input valid, input host_address, input port_number,
                    input parse_status, output ready);
endinterface

`default_nettype wire

// ----- sv/fpap_in_reg.sv -----
`default_nettype none

module fpap_in_reg
    import fpap_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpap_in_if.sink   i_in,
    input  wire logic i_take,
    output logic      o_valid,
    output t_in_item  o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     in_fire;

    assign i_in.ready = !r_valid || i_take;
    assign in_fire    = i_in.valid && i_in.ready;
    assign n_valid    = in_fire || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.char_code <= i_in.char_code;
            r_item.is_last   <= i_in.is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- sv/fpap_parse.sv -----
`default_nettype none

`include "assert_macros.svh"

module fpap_parse
    import fpap_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire logic     i_space,
    output logic          o_take,
    output logic          o_res_valid,
    output t_result       o_res
);

    logic [2:0]  r_comma_count;
    logic [15:0] r_acc;
    logic [31:0] r_addr;
    logic [7:0]  r_port_hi;
    logic        r_too_many;

    logic [2:0]  n_comma_count;
    logic [15:0] n_acc;
    logic [31:0] n_addr;
    logic [7:0]  n_port_hi;
    logic        n_too_many;

    assign o_take      = i_valid && (!i_item.is_last || i_space);
    assign o_res_valid = o_take && i_item.is_last;

    always_comb begin
        n_comma_count = r_comma_count;
        n_acc         = r_acc;
        n_addr        = r_addr;
        n_port_hi     = r_port_hi;
        n_too_many    = r_too_many;
        if (!r_too_many) begin
            if (i_item.char_code == SEP_CHAR) begin
                if (r_comma_count >= LAST_COMMA) begin
                    n_too_many = 1'b1;
                end else begin
                    if (r_comma_count < ADDR_NUMBERS) begin
                        n_addr = {r_addr[23:0], r_acc[7:0]};
                    end else begin
                        n_port_hi = r_acc[7:0];
                    end
                    n_comma_count = r_comma_count + 3'd1;
                    n_acc         = '0;
                end
            end else begin
                // acc * 10 + low nibble, wrapping at 16 bits
                n_acc = (r_acc << 3) + (r_acc << 1) + {12'd0, i_item.char_code[3:0]};
            end
        end
    end

    always_comb begin
        o_res.host_address = '0;
        o_res.port_number  = '0;
        priority if (n_too_many) begin
            o_res.parse_status = ST_TOO_MANY;
        end else if (n_comma_count != LAST_COMMA) begin
            o_res.parse_status = ST_TOO_FEW;
        end else begin
            o_res.parse_status = ST_OK;
            o_res.host_address = n_addr;
            o_res.port_number  = {n_port_hi, 8'd0} + n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comma_count <= '0;
            r_acc         <= '0;
            r_addr        <= '0;
            r_port_hi     <= '0;
            r_too_many    <= 1'b0;
        end else if (o_take) begin
            if (i_item.is_last) begin
                r_comma_count <= '0;
                r_acc         <= '0;
                r_addr        <= '0;
                r_port_hi     <= '0;
                r_too_many    <= 1'b0;
            end else begin
                r_comma_count <= n_comma_count;
                r_acc         <= n_acc;
                r_addr        <= n_addr;
                r_port_hi     <= n_port_hi;
                r_too_many    <= n_too_many;
            end
        end
    end

    `FPAP_ASSERT(a_comma_bound, i_clk, i_rst_n, r_comma_count <= LAST_COMMA)
    `FPAP_ASSERT_NEXT(a_clear_on_last, i_clk, i_rst_n, o_res_valid,
        r_comma_count == 3'd0 && r_acc == 16'd0 && !r_too_many)
    `FPAP_ASSERT_NEXT(a_too_many_sticky, i_clk, i_rst_n, r_too_many && !o_res_valid,
        r_too_many)

endmodule

`default_nettype wire

// ----- sv/fpap_out_reg.sv -----
`default_nettype none

module fpap_out_reg
    import fpap_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_res,
    output logic         o_space,
    fpap_out_if.source   o_out
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_space = !r_valid || o_out.ready;
    assign n_valid = i_valid || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.host_address = r_res.host_address;
    assign o_out.port_number  = r_res.port_number;
    assign o_out.parse_status = r_res.parse_status;

endmodule

`default_nettype wire

// ----- sv/ftp_port_argument_parser_core.sv -----
// PORT command argument parser, "n,n,n,n,m,m", one character per transaction.
// Input channel i_in: char_code and is_last; is_last marks the final character.
// Output channel o_out: host_address, port_number and parse_status (0 ok,
// 1 fewer than six numbers, 2 more than six). Address and port read zero
// unless the status is ok. Exactly one output transaction per input
// transaction with is_last set; other characters produce none.
// Throughput: one character per cycle unless a last character waits for space;
// a single multiply-by-ten-and-add lies between input and result register.
// An accepted last character passes the input register, then its result the
// result register, which presents it on o_out.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// parse state. After each last character the parse state clears by itself.
// When the receiver stalls the result holds in the output register; further
// non-last characters keep being taken, and a following last character
// waits in the input register until the result register frees up.
`default_nettype none

module ftp_port_argument_parser_core
    import fpap_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fpap_in_if.sink    i_in,
    fpap_out_if.source o_out
);

    logic     item_valid;
    t_in_item item;
    logic     take;
    logic     res_valid;
    t_result  res;
    logic     space;

    fpap_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    fpap_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .i_item      (item),
        .i_space     (space),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fpap_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import fpap_pkg::*;

    localparam int STALL_LIMIT   = 200;
    localparam int RANDOM_ITEMS  = 950;
    localparam int IDLE_PERCENT  = 6;

    typedef logic [7:0] t_chars[$];

    class port_arg_scoreboard;
        logic [2:0]  comma_cnt;
        logic [15:0] acc;
        logic [31:0] addr;
        logic [7:0]  port_hi;
        logic        overflow;
        t_result     endpoints[$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            comma_cnt = '0;
            acc       = '0;
            addr      = '0;
            port_hi   = '0;
            overflow  = 1'b0;
        endfunction

        function int pending_count();
            return endpoints.size();
        endfunction

        // Accepted input transaction: fold the character in, predict on the last one.
        function void note_char(logic [7:0] c, logic last);
            t_result r;
            if (!overflow) begin
                if (c == SEP_CHAR) begin
                    if (comma_cnt >= LAST_COMMA) begin
                        overflow = 1'b1;
                    end else begin
                        if (comma_cnt < ADDR_NUMBERS)
                            addr = {addr[23:0], acc[7:0]};
                        else
                            port_hi = acc[7:0];
                        comma_cnt = comma_cnt + 3'd1;
                        acc = '0;
                    end
                end else begin
                    acc = 16'(acc * 16'd10 + {12'd0, c[3:0]});
                end
            end
            if (last) begin
                r.host_address = '0;
                r.port_number  = '0;
                if (overflow) begin
                    r.parse_status = ST_TOO_MANY;
                end else if (comma_cnt != LAST_COMMA) begin
                    r.parse_status = ST_TOO_FEW;
                end else begin
                    r.parse_status = ST_OK;
                    r.host_address = addr;
                    r.port_number  = 16'({port_hi, 8'd0} + acc);
                end
                endpoints.push_back(r);
                clear();
            end
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] seen);
            $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, seen);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (endpoints.size() == 0) begin
                report("unexpected result", '0, got.host_address);
            end else begin
                want = endpoints.pop_front();
                if (got.host_address !== want.host_address)
                    report("host_address", want.host_address, got.host_address);
                if (got.port_number !== want.port_number)
                    report("port_number", want.port_number, got.port_number);
                if (got.parse_status !== want.parse_status)
                    report("parse_status", want.parse_status, got.parse_status);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   stall_cycles;
    port_arg_scoreboard sb;

    fpap_in_if  in_ch();
    fpap_out_if out_ch();

    ftp_port_argument_parser_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_char(in_ch.char_code, in_ch.is_last);
            if (out_ch.valid && out_ch.ready) begin
                got.host_address = out_ch.host_address;
                got.port_number  = out_ch.port_number;
                got.parse_status = t_status'(out_ch.parse_status);
                sb.check_result(got);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_chars to_chars(string t);
        t_chars q;
        for (int i = 0; i < t.len(); i++)
            q.push_back(t[i]);
        return q;
    endfunction

    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 11) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic t_chars build_argument();
        t_chars q;
        int kind;
        int numbers;
        int digits;
        kind = $urandom_range(0, 9);
        if (kind == 2) begin
            repeat ($urandom_range(1, 12))
                q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        numbers = (kind == 0) ? $urandom_range(1, 5) : (kind == 1) ? $urandom_range(7, 9) : 6;
        for (int k = 0; k < numbers; k++) begin
            if (k > 0)
                q.push_back(SEP_CHAR);
            digits = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
            repeat (digits)
                q.push_back(rand_char());
        end
        if (q.size() == 0)
            q.push_back(rand_char());
        return q;
    endfunction

    task automatic push_char(logic [7:0] c, logic last);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= c;
        in_ch.is_last   <= last;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_argument(t_chars q);
        foreach (q[i])
            push_char(q[i], i == q.size() - 1);
    endtask

    initial begin
        t_chars q;
        int sent;
        sb              = new();
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        quiet           = 1'b0;
        stall_cycles    = 0;
        in_ch.valid     = 1'b0;
        in_ch.char_code = '0;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty numbers, lone character, sixth comma with trailing junk
        send_argument(to_chars(",,,,,"));
        send_argument(to_chars("7"));
        send_argument(to_chars(",,,,,,9"));
        // byte extremes, non-digits and accumulator wrap
        q = {8'hFF, 8'h00};
        q = {q, to_chars("999,,,,,")};
        q.push_back(8'hFF);
        send_argument(q);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet = (sent >= 400 && sent < 600);
            q = build_argument();
            send_argument(q);
            sent += q.size();
        end
        quiet = 1'b0;
        in_ch.valid <= 1'b0;

        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
